// File: rtl/csev_pkg.sv
package csev_pkg;

  localparam int unsigned NumTermsDefault = 7;
  localparam int unsigned NumCoefRegs     = 7;
  localparam int unsigned CoefW           = 32;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned XW              = 32;
  localparam int unsigned TW              = 32;
  localparam int unsigned BW              = 41;
  localparam int unsigned DivStages       = 8;
  localparam int unsigned DivBitsPerStage = 4;

  // Range status codes.
  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusClamp = 2'd1;
  localparam logic [1:0] StatusZero  = 2'd2;

  // x = 8.0 in Q16.16; below it 32/x - 2 exceeds 2.0.
  localparam logic [XW-1:0] XClampLimit = 32'h0008_0000;
  // Part of 2^50 above the 32 quotient bits.
  localparam logic [XW-1:0] DivInitRem  = 32'h0004_0000;
  // 2.0 in Q3.29.
  localparam logic [TW-1:0] TTwo        = 32'h4000_0000;

  typedef struct packed {
    logic          valid;
    logic [1:0]    status;
    logic [TW-1:0] t;
    logic [BW-1:0] b0;
    logic [BW-1:0] b1;
    logic [BW-1:0] b2;
  } step_t;

  function automatic logic [CoefW-1:0] coef_reset(input int unsigned idx);
    logic [CoefW-1:0] v;
    case (idx)
      0:       v = 32'd4;
      1:       v = 32'd24;
      2:       v = 32'd220;
      3:       v = 32'd3105;
      4:       v = 32'd73978;
      5:       v = 32'd3617561;
      6:       v = 32'd863815001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/csev_div.sv
module csev_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [csev_pkg::XW-1:0]  x_i,
  output logic                     valid_o,
  output logic [1:0]               status_o,
  output logic [csev_pkg::TW-1:0]  t_o
);
  import csev_pkg::*;

  typedef struct packed {
    logic          valid;
    logic [1:0]    status;
    logic [XW-1:0] x;
    logic [XW-1:0] r;
    logic [XW-1:0] q;
  } div_t;

  div_t stg_q [DivStages];
  div_t stg_d [DivStages];
  div_t src   [DivStages];

  logic          t_valid_q;
  logic [1:0]    t_status_q;
  logic [TW-1:0] t_q, t_d;
  logic [XW:0]   t_full;

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    always_comb begin
      logic [XW:0] rr;
      if (k == 0) begin
        src[k].valid  = valid_i;
        src[k].x      = x_i;
        src[k].r      = DivInitRem;
        src[k].q      = '0;
        if (x_i == '0) begin
          src[k].status = StatusZero;
        end else if (x_i < XClampLimit) begin
          src[k].status = StatusClamp;
        end else begin
          src[k].status = StatusOk;
        end
      end else begin
        src[k] = stg_q[(k > 0) ? k - 1 : 0];
      end
      stg_d[k] = src[k];
      for (int j = 0; j < DivBitsPerStage; j++) begin
        rr = {stg_d[k].r, 1'b0};
        if (rr >= {1'b0, stg_d[k].x}) begin
          stg_d[k].r = XW'(rr - {1'b0, stg_d[k].x});
          stg_d[k].q = {stg_d[k].q[XW-2:0], 1'b1};
        end else begin
          stg_d[k].r = rr[XW-1:0];
          stg_d[k].q = {stg_d[k].q[XW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_q[k].valid <= 1'b0;
      end else if (en_i) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // Quotient is at most 2^31 unless clamped, so t fits 32 bits signed.
  always_comb begin
    t_full = {1'b0, stg_q[DivStages-1].q} - {1'b0, TTwo};
    if (stg_q[DivStages-1].status == StatusOk) begin
      t_d = t_full[TW-1:0];
    end else begin
      t_d = TTwo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_valid_q  <= 1'b0;
      t_status_q <= StatusOk;
      t_q        <= '0;
    end else if (en_i) begin
      t_valid_q  <= stg_q[DivStages-1].valid;
      t_status_q <= stg_q[DivStages-1].status;
      t_q        <= t_d;
    end
  end

  assign valid_o  = t_valid_q;
  assign status_o = t_status_q;
  assign t_o      = t_q;

endmodule

// File: rtl/csev_step.sv
module csev_step (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [csev_pkg::CoefW-1:0] coef_i,
  input  csev_pkg::step_t            step_i,
  output csev_pkg::step_t            step_o
);
  import csev_pkg::*;

  localparam int unsigned PlW = TW + 22;
  localparam int unsigned PhW = TW + 20;
  localparam int unsigned PW  = TW + BW;
  localparam int unsigned MW  = 44;
  localparam int unsigned SW  = 46;

  step_t a_q, b_q, c_q, c_d;
  logic signed [PlW-1:0] pl_d, pl_q;
  logic signed [PhW-1:0] ph_d, ph_q;
  logic signed [PW-1:0]  prod;
  logic signed [MW-1:0]  m_d, m_q;
  logic signed [SW-1:0]  s;
  logic                  neg;

  // Stage A: two partial products of t against the low and high halves of b.
  always_comb begin
    pl_d = $signed(step_i.t) * $signed({1'b0, step_i.b0[20:0]});
    ph_d = $signed(step_i.t) * $signed(step_i.b0[BW-1:21]);
  end

  // Stage B: combine, bias toward zero and drop 29 fraction bits.
  always_comb begin
    neg  = a_q.t[TW-1] ^ a_q.b0[BW-1];
    prod = (PW'(ph_q) <<< 21) + PW'(pl_q)
         + (neg ? PW'(30'h1FFF_FFFF) : PW'(0));
    m_d  = MW'(prod >>> 29);
  end

  // Stage C: subtract b2, add the coefficient and saturate.
  always_comb begin
    s = SW'(m_q) - SW'($signed(b_q.b1)) + SW'($signed(coef_i));
    c_d    = b_q;
    c_d.b2 = b_q.b1;
    c_d.b1 = b_q.b0;
    if (s > SW'(41'sh0FF_FFFF_FFFF)) begin
      c_d.b0 = {1'b0, {(BW-1){1'b1}}};
    end else if (s < -SW'(42'sh100_0000_0000)) begin
      c_d.b0 = {1'b1, {(BW-1){1'b0}}};
    end else begin
      c_d.b0 = s[BW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q.valid <= 1'b0;
      b_q.valid <= 1'b0;
      c_q.valid <= 1'b0;
    end else if (en_i) begin
      a_q  <= step_i;
      pl_q <= pl_d;
      ph_q <= ph_d;
      b_q  <= a_q;
      m_q  <= m_d;
      c_q  <= c_d;
    end
  end

  assign step_o = c_q;

endmodule

// File: rtl/chebyshev_series_eval_core.sv
// Chebyshev series evaluator using the Clenshaw recurrence.
// Input channel: x_value_i (unsigned Q16.16) with in_valid_i; a beat is taken
// when in_valid_i is high and in_stall_o is low. Output channel: series_value_o
// (signed Q2.30) and range_status_o with out_valid_o; a beat leaves when
// out_valid_o is high and out_stall_i is low.
// The coefficients are written through the cfg port (index, data, valid/ready,
// ready is always high); writes to an index past the last register are dropped.
// Configuration is expected only while the pipeline is empty.
// A beat passes through the 2^50/x divider, a register that forms and clamps t,
// the registers of each recurrence step (split multiply, truncate, add and
// saturate) and one output register. While no valid output is stalled, the
// divider yields four quotient bits a cycle and throughput is one beat per cycle.
// When the receiver stalls a valid output, the whole pipeline holds and
// in_stall_o rises; nothing is lost or repeated.
// Reset clears all valid bits and loads the coefficient reset table.
module chebyshev_series_eval_core #(
  parameter int unsigned NUM_TERMS = csev_pkg::NumTermsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [csev_pkg::XW-1:0]      x_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  series_value_o,
  output logic [1:0]                   range_status_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [csev_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [csev_pkg::CoefW-1:0]   cfg_data_i
);
  import csev_pkg::*;

  localparam int unsigned NumSteps = NUM_TERMS - 1;

  logic             en;
  logic [CoefW-1:0] coef_q [NumCoefRegs];
  logic             t_valid;
  logic [1:0]       t_status;
  logic [TW-1:0]    t_val;
  step_t            chain [NumSteps+1];

  logic             out_valid_q;
  logic [31:0]      out_value_q, out_value_d;
  logic [1:0]       out_status_q;
  logic signed [BW:0] diff, half;

  // A held output freezes every stage at once, so bubbles stay in place.
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoefRegs; i++) begin
        coef_q[i] <= coef_reset(i);
      end
    end else if (cfg_valid_i && (32'(cfg_index_i) < NumCoefRegs)) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  csev_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .x_i      (x_value_i),
    .valid_o  (t_valid),
    .status_o (t_status),
    .t_o      (t_val)
  );

  // The recurrence starts from b0 = c0 with b1 and b2 at zero.
  always_comb begin
    chain[0].valid  = t_valid;
    chain[0].status = t_status;
    chain[0].t      = t_val;
    chain[0].b0     = BW'($signed(coef_q[0]));
    chain[0].b1     = '0;
    chain[0].b2     = '0;
  end

  for (genvar i = 1; i <= NumSteps; i++) begin : g_step
    logic [CoefW-1:0] coef;
    if (i < NumCoefRegs) begin : g_reg
      assign coef = coef_q[i];
    end else begin : g_none
      assign coef = '0;
    end

    csev_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .coef_i (coef),
      .step_i (chain[i-1]),
      .step_o (chain[i])
    );
  end

  // Result is (b0 - b2) / 2 rounded toward zero, then saturated to Q2.30; a zero x gives 0.
  always_comb begin
    diff = $signed({chain[NumSteps].b0[BW-1], chain[NumSteps].b0})
         - $signed({chain[NumSteps].b2[BW-1], chain[NumSteps].b2});
    half = $signed(diff + (BW+1)'(diff[BW])) >>> 1;
    if (chain[NumSteps].status == StatusZero) begin
      out_value_d = '0;
    end else if (half > (BW+1)'(32'sh7FFF_FFFF)) begin
      out_value_d = 32'h7FFF_FFFF;
    end else if (half < -(BW+1)'(33'sh0_8000_0000)) begin
      out_value_d = 32'h8000_0000;
    end else begin
      out_value_d = half[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= StatusOk;
      out_value_q  <= '0;
    end else if (en) begin
      out_valid_q  <= chain[NumSteps].valid;
      out_status_q <= chain[NumSteps].status;
      out_value_q  <= out_value_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign series_value_o = out_value_q;
  assign range_status_o = out_status_q;

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (range_status_o == StatusZero) |-> series_value_o == '0)
    else $error("zero argument gave a nonzero result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> range_status_o != 2'd3)
    else $error("undefined range status");

  a_hold_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(chain[NumSteps].valid) && $stable(t_valid))
    else $error("pipeline moved during a stall");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import csev_pkg::*;

  localparam int unsigned Latency = 10 + 3 * (NumTermsDefault - 1);
  localparam logic signed [79:0] BMax = 80'sh00_0000_00FF_FFFF_FFFF;
  localparam logic signed [79:0] BMin = -80'sh00_0000_0100_0000_0000;
  localparam logic signed [79:0] TwoQ29 = 80'sd1073741824;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
  } series_result_t;

  // The scoreboard keeps its own copy of the coefficient registers and a
  // queue of the series results still owed by the block, oldest first.
  class series_scoreboard;
    logic signed [31:0] coefs [8];
    series_result_t     owed [$];
    int                 errors;
    int                 checked;

    function void load_reset();
      for (int i = 0; i < 8; i++) coefs[i] = coef_reset(i);
    endfunction

    function void write_coef(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      // Indexes past the last register are dropped by the block too.
      if (idx < NumCoefRegs) coefs[idx] = data;
    endfunction

    function automatic series_result_t evaluate(logic [31:0] x);
      series_result_t r;
      logic [63:0] quot;
      logic signed [79:0] t, b0, b1, b2, d;
      r.status = StatusOk;
      if (x == 0) begin
        r.value  = '0;
        r.status = StatusZero;
        return r;
      end
      quot = (64'd1 << 50) / {32'd0, x};
      t = $signed({16'd0, quot}) - TwoQ29;
      if (t > TwoQ29) begin
        t = TwoQ29;
        r.status = StatusClamp;
      end
      b0 = coefs[0];
      b1 = '0;
      b2 = '0;
      for (int i = 1; i < NumTermsDefault && i < 8; i++) begin
        b2 = b1;
        b1 = b0;
        // The product is exact in 80 bits; signed division truncates toward zero.
        b0 = (t * b1) / 80'sd536870912 - b2 + coefs[i];
        if (b0 > BMax) b0 = BMax;
        if (b0 < BMin) b0 = BMin;
      end
      d = (b0 - b2) / 80'sd2;
      if (d > 80'sd2147483647) d = 80'sd2147483647;
      if (d < -80'sd2147483648) d = -80'sd2147483648;
      r.value = d[31:0];
      return r;
    endfunction

    function void note_input(logic [31:0] x);
      owed.push_back(evaluate(x));
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task check_result(logic [31:0] value, logic [1:0] status);
      series_result_t e;
      checked++;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result value=%h status=%0d", value, status));
        return;
      end
      e = owed.pop_front();
      if (value !== e.value)
        report($sformatf("series_value %h, predicted %h", value, e.value));
      if (status !== e.status)
        report($sformatf("range_status %0d, predicted %0d", status, e.status));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [XW-1:0]       x_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [31:0]         series_value_o;
  logic [1:0]          range_status_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CoefW-1:0]    cfg_data_i = '0;

  series_scoreboard board = new();
  int sent;
  int cfg_writes;
  // 0: never stall, 1: light random stalls, 2: heavy random stalls.
  int stall_mode;

  chebyshev_series_eval_core uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .x_value_i,
    .out_valid_o, .out_stall_i, .series_value_o, .range_status_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // Sample at the rising edge: the block updates by nonblocking assignment,
  // so these reads see the values that held just before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.note_input(x_value_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(series_value_o, range_status_o);
  end

  // The receiver changes its stall behavior now and then, including long
  // stretches without any stall at all.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i = 1'b0;
      1: out_stall_i = ($urandom_range(0, 9) < 3);
      default: out_stall_i = ($urandom_range(0, 9) < 8);
    endcase
  end

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk_i);
  endtask

  // Drive one beat and hold it until the block takes it; valid stays high
  // when the caller sends again right away.
  task automatic send_x(logic [31:0] x);
    in_valid_i = 1'b1;
    x_value_i  = x;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic pause_sender(int n);
    in_valid_i = 1'b0;
    x_value_i  = $urandom;
    idle_cycles(n);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (board.owed.size() != 0) @(negedge clk_i);
    idle_cycles(Latency + 5);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_coef(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] pick_x();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 32'h0007_FFFF);   // clamped region
      1:       return $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(1, 16);
      2, 3, 4: return $urandom_range(32'h0008_0000, 32'h0040_0000);
      5:       return $urandom_range(32'h0007_FFF0, 32'h0008_0010);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_traffic(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && count > 0) begin
        send_x(pick_x());
        burst--;
        count--;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
  endtask

  task automatic load_coefs(int kind);
    logic [31:0] v;
    for (int i = 0; i < NumCoefRegs; i++) begin
      case (kind)
        0:       v = 32'h7FFF_FFFF;
        1:       v = 32'h8000_0000;
        2:       v = '0;
        3:       v = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        default: v = $urandom;
      endcase
      write_cfg(CfgIdxW'(i), v);
    end
  endtask

  initial begin
    logic [31:0] directed [] = '{32'd0, 32'd1, 32'h0000_FFFF, 32'h0001_0000,
      32'h0007_FFFF, 32'h0008_0000, 32'h0008_0001, 32'h0010_0000, 32'h0020_0000,
      32'h0100_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
      32'h5555_5555, 32'd0};
    board.load_reset();
    stall_mode = 0;
    idle_cycles(3);
    rst_ni = 1'b1;
    idle_cycles(2);

    // Reset coefficients first, over the field extremes and both special cases.
    foreach (directed[i]) send_x(directed[i]);
    drain();
    // An out-of-range register index must leave the coefficients alone.
    write_cfg(CfgIdxW'(NumCoefRegs), 32'hDEAD_BEEF);
    foreach (directed[i]) send_x(directed[i]);
    random_traffic(200);

    // Several coefficient sets: both extremes, zero, alternating signs and
    // random ones. The saturating sets push the recurrence to its limits.
    for (int phase = 0; phase < 9; phase++) begin
      drain();
      load_coefs(phase < 4 ? phase : 4);
      foreach (directed[i]) send_x(directed[i]);
      random_traffic(180);
    end
    drain();
    load_coefs(4);
    random_traffic(150);
    drain();

    $display("testbench: %0d x beats sent, %0d results checked, %0d register writes",
             sent, board.checked, cfg_writes);
    $display("testbench: coefficient sets covered reset, extremes, zero and random");
    if (board.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TIMEOUT: %0d results still owed", board.owed.size());
    $display("testbench: errors");
    $finish;
  end

endmodule
